/* rtl/core/enveloped_sine_tone_generator_unit_macros.svh */
// assertion macros shared by the tone generator rtl
// expects aclk and aresetn in the scope where a macro is used
`ifndef ENVELOPED_SINE_TONE_GENERATOR_UNIT_MACROS_SVH
`define ENVELOPED_SINE_TONE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication, off while in reset
`define ESTG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("estg: same-cycle check failed");

// next-cycle implication, off while in reset
`define ESTG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("estg: next-cycle check failed");

`endif

/* rtl/core/estg_pkg.sv */
// shared types, constants and constant tables of the tone generator
// no dependencies
package estg_pkg;

    localparam int DEFAULT_FRAME_BITS      = 20;
    localparam int DEFAULT_SINE_TABLE_BITS = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TOTAL_W    = 20;
    localparam int SINE_W     = 15;
    localparam int SAMPLE_W   = 16;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE  = 3'd3;

    localparam logic [31:0]        RST_PHASE_INC    = 32'd42852281;
    localparam logic [TOTAL_W-1:0] RST_TOTAL_FRAMES = 20'd11025;
    localparam logic [31:0]        RST_RAMP_GAIN    = 32'd973915;
    localparam logic               RST_STEREO_MODE  = 1'b1;

    // shared multiplier
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [MUL_W-1:0]  ONE_Q30     = 33'h0_4000_0000;
    localparam logic [PROD_W-1:0] ONE_Q32     = 66'h1_0000_0000;
    localparam logic [MUL_W-1:0]  HALF_PI_Q30 = 33'd1686629713;
    localparam logic [MUL_W-1:0]  GAIN_Q16    = 33'd858967245;
    localparam logic [MUL_W-1:0]  SINE_SCALE  = 33'd32767;

    localparam int HORNER_STEPS = 6;
    localparam int STEP_W       = 3;

    localparam logic [63:0] TWO_P32 = 64'h1_0000_0000;
    localparam logic [MUL_W-1:0] RECIP_D0 = 33'(TWO_P32 / 156);
    localparam logic [MUL_W-1:0] RECIP_D1 = 33'(TWO_P32 / 110);
    localparam logic [MUL_W-1:0] RECIP_D2 = 33'(TWO_P32 / 72);
    localparam logic [MUL_W-1:0] RECIP_D3 = 33'(TWO_P32 / 42);
    localparam logic [MUL_W-1:0] RECIP_D4 = 33'(TWO_P32 / 20);
    localparam logic [MUL_W-1:0] RECIP_D5 = 33'(TWO_P32 / 6);

    // horner divisors of the sine series
    function automatic logic [MUL_W-1:0] horner_div(input logic [STEP_W-1:0] step);
        logic [MUL_W-1:0] d;
        case (step)
            3'd0: d = 33'd156;
            3'd1: d = 33'd110;
            3'd2: d = 33'd72;
            3'd3: d = 33'd42;
            3'd4: d = 33'd20;
            default: d = 33'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor), quotient estimate is low by at most one
    function automatic logic [MUL_W-1:0] horner_recip(input logic [STEP_W-1:0] step);
        logic [MUL_W-1:0] r;
        case (step)
            3'd0: r = RECIP_D0;
            3'd1: r = RECIP_D1;
            3'd2: r = RECIP_D2;
            3'd3: r = RECIP_D3;
            3'd4: r = RECIP_D4;
            default: r = RECIP_D5;
        endcase
        return r;
    endfunction

    typedef enum logic [3:0] {
        ST_FILL_X,
        ST_FILL_X2,
        ST_FILL_T0,
        ST_FILL_Q,
        ST_FILL_R,
        ST_FILL_C,
        ST_FILL_E,
        ST_FILL_W,
        ST_IDLE,
        ST_ATT,
        ST_REL,
        ST_ENV,
        ST_GAIN,
        ST_MAG,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0]        phase_inc;
        logic [TOTAL_W-1:0] total_frames;
        logic [31:0]        ramp_gain;
        logic               stereo;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic restart;
        logic out_free;
    } core_ctrl_t;

    typedef struct packed {
        logic ready;
        logic done;
    } core_stat_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                last;
    } res_t;

endpackage

/* rtl/core/enveloped_sine_tone_generator_unit.sv */
// top level of the enveloped sine tone generator: config registers, handshakes, result beat
// depends on estg_pkg, estg_core and enveloped_sine_tone_generator_unit_macros.svh
//
//   port group   dir   handshake            payload
//   s_           in    s_valid / s_ready    s_restart
//   m_           out   m_valid / m_ready    m_left_sample, m_right_sample, m_last_frame
//   cfg_         in    cfg_wr_en            cfg_index, cfg_wr_data
//
// after reset the sine table is built in place over 2^SINE_TABLE_BITS + 1
// entries, one entry after another; s_ready stays low meanwhile
// for each accepted beat the core runs attack, release, envelope, gain and sine
// through the shared multiplier, then the result beat is loaded; s_ready returns
// with m_valid, so a new beat is taken only once the last frame is done, and
// m_ready low with a beat still waiting stalls the core in its last step
// reset is synchronous, active low, and restores the register defaults
`include "enveloped_sine_tone_generator_unit_macros.svh"

module enveloped_sine_tone_generator_unit #(
    parameter int FRAME_BITS      = estg_pkg::DEFAULT_FRAME_BITS,
    parameter int SINE_TABLE_BITS = estg_pkg::DEFAULT_SINE_TABLE_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_restart,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [estg_pkg::SAMPLE_W-1:0] m_left_sample,
    output logic signed [estg_pkg::SAMPLE_W-1:0] m_right_sample,
    output logic                               m_last_frame,

    input  logic                               cfg_wr_en,
    input  logic [estg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [estg_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    estg_pkg::cfg_t       cfg_reg, cfg_next;
    estg_pkg::core_ctrl_t core_ctrl;
    estg_pkg::core_stat_t core_stat;
    estg_pkg::res_t       core_res;

    // output beat register, parts the core from the consumer
    logic                 m_valid_reg, m_valid_next;
    estg_pkg::res_t       res_reg, res_next;
    logic                 out_free;

    // register writes, unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                estg_pkg::CFG_PHASE_INC:    cfg_next.phase_inc    = cfg_wr_data;
                estg_pkg::CFG_TOTAL_FRAMES: cfg_next.total_frames =
                                                cfg_wr_data[estg_pkg::TOTAL_W-1:0];
                estg_pkg::CFG_RAMP_GAIN:    cfg_next.ramp_gain    = cfg_wr_data;
                estg_pkg::CFG_STEREO_MODE:  cfg_next.stereo       = cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_inc    <= estg_pkg::RST_PHASE_INC;
            cfg_reg.total_frames <= estg_pkg::RST_TOTAL_FRAMES;
            cfg_reg.ramp_gain    <= estg_pkg::RST_RAMP_GAIN;
            cfg_reg.stereo       <= estg_pkg::RST_STEREO_MODE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // core may finish whenever the beat register is empty or draining
    assign out_free          = !m_valid_reg || m_ready;
    assign s_ready           = core_stat.ready;
    assign core_ctrl.start   = s_valid && core_stat.ready;
    assign core_ctrl.restart = s_restart;
    assign core_ctrl.out_free = out_free;

    estg_core #(
        .FRAME_BITS      (FRAME_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .ctrl    (core_ctrl),
        .stat    (core_stat),
        .res     (core_res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (core_stat.done) begin
            m_valid_next = 1'b1;
            res_next     = core_res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_left_sample  = res_reg.left;
    assign m_right_sample = res_reg.right;
    assign m_last_frame   = res_reg.last;

    // a result never overwrites a beat still waiting
    `ESTG_ASSERT_IMP(a_done_needs_slot, core_stat.done, out_free)
    // one frame in flight: an accepted beat drops ready
    `ESTG_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    // a new result beat only follows a finished frame
    `ESTG_ASSERT_IMP(a_beat_from_core, $rose(m_valid_reg), $past(core_stat.done))

endmodule

/* rtl/core/estg_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module estg_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 1025
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/estg_mul.sv */
// shared unsigned multiplier with registered product
// depends on estg_pkg
module estg_mul (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [estg_pkg::MUL_W-1:0]   a,
    input  logic [estg_pkg::MUL_W-1:0]   b,
    output logic [estg_pkg::PROD_W-1:0]  p
);

    logic [estg_pkg::PROD_W-1:0] p_reg;

    // product holds while idle so later steps can reread it
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= estg_pkg::PROD_W'(a) * estg_pkg::PROD_W'(b);
        end
    end

    assign p = p_reg;

endmodule

/* rtl/core/estg_core.sv */
// sequencer and datapath: sine table fill, then per-frame envelope and sample
// depends on estg_pkg, estg_mul, estg_ram
module estg_core #(
    parameter int FRAME_BITS      = estg_pkg::DEFAULT_FRAME_BITS,
    parameter int SINE_TABLE_BITS = estg_pkg::DEFAULT_SINE_TABLE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  estg_pkg::cfg_t         cfg,
    input  estg_pkg::core_ctrl_t   ctrl,
    output estg_pkg::core_stat_t   stat,
    output estg_pkg::res_t         res
);

    localparam int ROM_DEPTH = (2 ** SINE_TABLE_BITS) + 1;
    localparam int ROM_AW    = SINE_TABLE_BITS + 1;
    localparam int CNT_W     = (FRAME_BITS > estg_pkg::TOTAL_W) ? FRAME_BITS
                                                                 : estg_pkg::TOTAL_W;
    localparam int MW        = estg_pkg::MUL_W;
    localparam int PW        = estg_pkg::PROD_W;
    localparam int SW        = estg_pkg::SINE_W;
    localparam logic [ROM_AW-1:0] ROM_LAST = ROM_AW'(ROM_DEPTH - 1);

    estg_pkg::state_t state_reg, state_next;

    logic [ROM_AW-1:0]            k_reg, k_next;
    logic [estg_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [30:0]                  x_reg, x_next;
    logic [31:0]                  x2_reg, x2_next;
    logic [31:0]                  n_reg, n_next;
    logic [31:0]                  q_reg, q_next;
    logic [MW-1:0]                att_reg, att_next;
    logic [FRAME_BITS-1:0]        idx_reg, idx_next;
    logic [31:0]                  phase_reg, phase_next;

    logic          mul_en;
    logic [MW-1:0] mul_a, mul_b;
    logic [PW-1:0] prod;

    logic          ram_we;
    logic [SW-1:0] ram_wdata, ram_rdata;
    logic [ROM_AW-1:0] rom_addr;

    // fill datapath
    logic [30:0] x_new;
    logic [31:0] x2_new, n_new, q0, rem, q_fix, t_wide;
    logic [30:0] t_new, s_new;
    logic [46:0] round_sum;
    logic [MW-1:0] div_d;

    // frame datapath
    logic [SINE_TABLE_BITS-1:0] offs;
    logic [CNT_W-1:0] idx_ext, total_ext, rel_count;
    logic             last;
    logic [MW-1:0]    prod_clamp, env_new;
    logic [29:0]      gain_new;
    logic [SW-1:0]    mag;
    logic [estg_pkg::SAMPLE_W-1:0] sample;

    estg_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    estg_ram #(
        .WIDTH (SW),
        .DEPTH (ROM_DEPTH)
    ) u_rom (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (k_reg),
        .wdata (ram_wdata),
        .raddr (rom_addr),
        .rdata (ram_rdata)
    );

    // quarter-wave addressing, mirrored in odd quadrants
    assign offs     = phase_reg[29 -: SINE_TABLE_BITS];
    assign rom_addr = phase_reg[30] ? (ROM_LAST - {1'b0, offs}) : {1'b0, offs};

    assign x_new     = prod[SINE_TABLE_BITS +: 31];
    assign x2_new    = prod[61:30];
    assign n_new     = prod[61:30];
    assign q0        = prod[63:32];
    assign div_d     = estg_pkg::horner_div(step_reg);
    assign rem       = n_reg - prod[31:0];
    assign q_fix     = (rem >= div_d[31:0]) ? (q_reg + 32'd1) : q_reg;
    assign t_wide    = 32'h4000_0000 - q_fix;
    assign t_new     = t_wide[30:0];
    assign s_new     = prod[60:30];
    assign round_sum = {1'b0, prod[45:0]} + 47'h2000_0000;
    assign ram_wdata = round_sum[44:30];

    assign idx_ext    = CNT_W'(idx_reg);
    assign total_ext  = CNT_W'(cfg.total_frames);
    assign rel_count  = (idx_ext < total_ext) ? (total_ext - idx_ext) : '0;
    assign last       = ({1'b0, idx_ext} + (CNT_W + 1)'(1)) >= {1'b0, total_ext};
    assign prod_clamp = (prod > estg_pkg::ONE_Q32) ? estg_pkg::ONE_Q32[MW-1:0] : prod[MW-1:0];
    assign env_new    = prod[48:16];
    assign gain_new   = prod[61:32];
    assign mag        = prod[45:31];
    assign sample     = phase_reg[31] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};

    assign res.left  = sample;
    assign res.right = cfg.stereo ? sample : '0;
    assign res.last  = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= estg_pkg::ST_FILL_X;
            k_reg     <= '0;
            step_reg  <= '0;
            idx_reg   <= '0;
            phase_reg <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        x2_reg  <= x2_next;
        n_reg   <= n_next;
        q_reg   <= q_next;
        att_reg <= att_next;
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        n_next     = n_reg;
        q_next     = q_reg;
        att_next   = att_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        ram_we     = 1'b0;
        stat.ready = 1'b0;
        stat.done  = 1'b0;

        case (state_reg)
            estg_pkg::ST_FILL_X: begin
                mul_en     = 1'b1;
                mul_a      = MW'(k_reg);
                mul_b      = estg_pkg::HALF_PI_Q30;
                state_next = estg_pkg::ST_FILL_X2;
            end
            estg_pkg::ST_FILL_X2: begin
                x_next     = x_new;
                mul_en     = 1'b1;
                mul_a      = MW'(x_new);
                mul_b      = MW'(x_new);
                state_next = estg_pkg::ST_FILL_T0;
            end
            estg_pkg::ST_FILL_T0: begin
                x2_next    = x2_new;
                step_next  = '0;
                mul_en     = 1'b1;
                mul_a      = MW'(x2_new);
                mul_b      = estg_pkg::ONE_Q30;
                state_next = estg_pkg::ST_FILL_Q;
            end
            estg_pkg::ST_FILL_Q: begin
                n_next     = n_new;
                mul_en     = 1'b1;
                mul_a      = MW'(n_new);
                mul_b      = estg_pkg::horner_recip(step_reg);
                state_next = estg_pkg::ST_FILL_R;
            end
            estg_pkg::ST_FILL_R: begin
                q_next     = q0;
                mul_en     = 1'b1;
                mul_a      = MW'(q0);
                mul_b      = div_d;
                state_next = estg_pkg::ST_FILL_C;
            end
            estg_pkg::ST_FILL_C: begin
                mul_en = 1'b1;
                mul_b  = MW'(t_new);
                if (step_reg == estg_pkg::STEP_W'(estg_pkg::HORNER_STEPS - 1)) begin
                    mul_a      = MW'(x_reg);
                    state_next = estg_pkg::ST_FILL_E;
                end else begin
                    mul_a      = MW'(x2_reg);
                    step_next  = step_reg + 1'b1;
                    state_next = estg_pkg::ST_FILL_Q;
                end
            end
            estg_pkg::ST_FILL_E: begin
                mul_en     = 1'b1;
                mul_a      = MW'(s_new);
                mul_b      = estg_pkg::SINE_SCALE;
                state_next = estg_pkg::ST_FILL_W;
            end
            estg_pkg::ST_FILL_W: begin
                ram_we = 1'b1;
                if (k_reg == ROM_LAST) begin
                    state_next = estg_pkg::ST_IDLE;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = estg_pkg::ST_FILL_X;
                end
            end
            estg_pkg::ST_IDLE: begin
                stat.ready = 1'b1;
                if (ctrl.start) begin
                    if (ctrl.restart) begin
                        idx_next   = '0;
                        phase_next = '0;
                    end
                    state_next = estg_pkg::ST_ATT;
                end
            end
            estg_pkg::ST_ATT: begin
                mul_en     = 1'b1;
                mul_a      = MW'(idx_reg);
                mul_b      = MW'(cfg.ramp_gain);
                state_next = estg_pkg::ST_REL;
            end
            estg_pkg::ST_REL: begin
                att_next   = prod_clamp;
                mul_en     = 1'b1;
                mul_a      = MW'(rel_count);
                mul_b      = MW'(cfg.ramp_gain);
                state_next = estg_pkg::ST_ENV;
            end
            estg_pkg::ST_ENV: begin
                mul_en     = 1'b1;
                mul_a      = att_reg;
                mul_b      = MW'(prod_clamp[32:16]);
                state_next = estg_pkg::ST_GAIN;
            end
            estg_pkg::ST_GAIN: begin
                mul_en     = 1'b1;
                mul_a      = env_new;
                mul_b      = estg_pkg::GAIN_Q16;
                state_next = estg_pkg::ST_MAG;
            end
            estg_pkg::ST_MAG: begin
                mul_en     = 1'b1;
                mul_a      = MW'(gain_new);
                mul_b      = MW'(ram_rdata);
                state_next = estg_pkg::ST_DONE;
            end
            estg_pkg::ST_DONE: begin
                if (ctrl.out_free) begin
                    stat.done = 1'b1;
                    if (last) begin
                        idx_next   = '0;
                        phase_next = '0;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        phase_next = phase_reg + cfg.phase_inc;
                    end
                    state_next = estg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = estg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
